// File: design/rvss_pkg.sv
`default_nettype none

package rvss_pkg;

  localparam int unsigned REG_COUNT = 16;
  localparam int unsigned RF_AW     = 4;
  localparam int unsigned UPC_W     = 4;

  // RISC-V major opcodes and funct3 codes handled by the core.
  localparam logic [6:0] OPC_LUI   = 7'b0110111;
  localparam logic [6:0] OPC_JALR  = 7'b1100111;
  localparam logic [6:0] OPC_ADDI  = 7'b0010011;
  localparam logic [6:0] OPC_ADD   = 7'b0110011;
  localparam logic [6:0] OPC_LOAD  = 7'b0000011;
  localparam logic [6:0] OPC_STORE = 7'b0100011;
  localparam logic [2:0] F3_WORD   = 3'b010;
  localparam logic [2:0] F3_BYTE   = 3'b000;

  // Item opcodes.
  localparam logic ITEM_LOAD = 1'b0;
  localparam logic ITEM_EXEC = 1'b1;

  // Microprogram addresses.
  localparam logic [UPC_W-1:0] UPC_IDLE    = 4'd0;
  localparam logic [UPC_W-1:0] UPC_LD_IDX  = 4'd1;
  localparam logic [UPC_W-1:0] UPC_LD_WAIT = 4'd2;
  localparam logic [UPC_W-1:0] UPC_LD_WR   = 4'd3;
  localparam logic [UPC_W-1:0] UPC_FETCH   = 4'd4;
  localparam logic [UPC_W-1:0] UPC_F_WAIT  = 4'd5;
  localparam logic [UPC_W-1:0] UPC_F_READ  = 4'd6;
  localparam logic [UPC_W-1:0] UPC_DECODE  = 4'd7;
  localparam logic [UPC_W-1:0] UPC_RF_READ = 4'd8;
  localparam logic [UPC_W-1:0] UPC_EXEC    = 4'd9;
  localparam logic [UPC_W-1:0] UPC_M_WAIT  = 4'd10;
  localparam logic [UPC_W-1:0] UPC_M_READ  = 4'd11;
  localparam logic [UPC_W-1:0] UPC_MEM     = 4'd12;
  localparam logic [UPC_W-1:0] UPC_WB      = 4'd13;

  typedef enum logic [1:0] {
    RED_HOLD = 2'd0,
    RED_PC   = 2'd1,
    RED_ADDR = 2'd2,
    RED_LOAD = 2'd3
  } red_src_e;

  typedef enum logic [2:0] {
    J_NEXT     = 3'd0,
    J_ALWAYS   = 3'd1,
    J_DISPATCH = 3'd2,
    J_NOMEM    = 3'd3,
    J_WBWAIT   = 3'd4
  } jump_e;

  typedef struct packed {
    red_src_e         red_src;
    logic             insn_ld;
    logic             alu_ld;
    logic             mem_op;
    logic             load_wr;
    logic             wb;
    jump_e            jump;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_accept;
    logic in_exec;
    logic is_mem;
    logic out_busy;
  } stat_t;

  function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] upc);
    ctrl_t cw;
    cw         = '0;
    cw.red_src = RED_HOLD;
    cw.jump    = J_NEXT;
    cw.target  = UPC_IDLE;
    case (upc)
      UPC_IDLE: begin
        cw.jump   = J_DISPATCH;
        cw.target = UPC_FETCH;
      end
      UPC_LD_IDX:  cw.red_src = RED_LOAD;
      UPC_LD_WAIT: cw.jump = J_NEXT;
      UPC_LD_WR: begin
        cw.load_wr = 1'b1;
        cw.jump    = J_ALWAYS;
      end
      UPC_FETCH:   cw.red_src = RED_PC;
      UPC_F_WAIT:  cw.jump = J_NEXT;
      UPC_F_READ:  cw.jump = J_NEXT;
      UPC_DECODE:  cw.insn_ld = 1'b1;
      UPC_RF_READ: cw.jump = J_NEXT;
      UPC_EXEC: begin
        cw.red_src = RED_ADDR;
        cw.alu_ld  = 1'b1;
        cw.jump    = J_NOMEM;
        cw.target  = UPC_WB;
      end
      UPC_M_WAIT:  cw.jump = J_NEXT;
      UPC_M_READ:  cw.jump = J_NEXT;
      UPC_MEM:     cw.mem_op = 1'b1;
      UPC_WB: begin
        cw.wb   = 1'b1;
        cw.jump = J_WBWAIT;
      end
      default:     cw.jump = J_ALWAYS;
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// File: design/rv32e_subset_core_step.sv
`default_nettype none

// Small RV32E-style core run by a microprogram. A load beat (opcode 0) writes
// one word into both the instruction and data stores. An execute beat
// (opcode 1) fetches the word at pc, runs LUI, JALR, ADDI, ADD, LW/LBU or
// SB/SW and returns one result, which may wait in the result register on a
// stalled output. A new beat is taken only once the previous one has
// finished. Every store access first passes through a registered
// address-modulo unit, and the instruction store, the register file and the
// data store each have a registered read.
// Stores are not cleared at reset; the 16 registers read as zero until
// written. Writing start_pc is taken only while no item is in flight.
module rv32e_subset_core_step #(
  parameter int unsigned MEM_WORDS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        opcode_i,
  input  wire logic [9:0]  load_index_i,
  input  wire logic [31:0] load_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [31:0] step_pc_o,
  output logic      [31:0] instruction_o,
  output logic             wrote_o,
  output logic      [3:0]  dest_reg_o,
  output logic      [31:0] dest_value_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] start_pc_i
);

  localparam int unsigned IDX_W = $clog2(MEM_WORDS);

  rvss_pkg::ctrl_t cw;
  rvss_pkg::stat_t stat;
  logic            seq_idle;
  logic            in_accept;
  logic            cfg_we;
  logic            is_mem;
  logic            out_busy;

  // A configuration beat takes priority over an item beat in the same cycle.
  assign in_stall_o  = !seq_idle || cfg_valid_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = seq_idle;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  assign stat.in_accept = in_accept;
  assign stat.in_exec   = (opcode_i == rvss_pkg::ITEM_EXEC);
  assign stat.is_mem    = is_mem;
  assign stat.out_busy  = out_busy;

  rvss_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cw_o   (cw),
    .idle_o (seq_idle)
  );

  rvss_datapath #(
    .MEM_WORDS (MEM_WORDS),
    .IDX_W     (IDX_W)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cw_i          (cw),
    .in_accept_i   (in_accept),
    .load_index_i  (load_index_i),
    .load_word_i   (load_word_i),
    .cfg_we_i      (cfg_we),
    .start_pc_i    (start_pc_i),
    .out_stall_i   (out_stall_i),
    .is_mem_o      (is_mem),
    .out_busy_o    (out_busy),
    .out_valid_o   (out_valid_o),
    .step_pc_o     (step_pc_o),
    .instruction_o (instruction_o),
    .wrote_o       (wrote_o),
    .dest_reg_o    (dest_reg_o),
    .dest_value_o  (dest_value_o)
  );

  a_accept_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> seq_idle)
    else $error("item beat accepted while the sequencer was busy");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !seq_idle)
    else $error("sequencer did not leave idle after an item beat");

  a_result_from_wb : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cw.wb))
    else $error("result appeared outside the write-back step");

  a_load_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.load_wr && !out_valid_o) |=> !out_valid_o)
    else $error("load beat produced a result");

endmodule

`default_nettype wire

// File: design/rvss_idxmod.sv
`default_nettype none

// Reduces a word address modulo the store depth. The address and the result
// are both registered; the result stays put while no new address is launched.
module rvss_idxmod #(
  parameter int unsigned MEM_WORDS = 1024,
  parameter int unsigned IDX_W     = 10
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [29:0]      word_addr_i,
  output logic      [IDX_W-1:0] idx_o
);

  localparam bit POW2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;

  logic [IDX_W-1:0] idx_q;

  generate
    if (POW2) begin : g_mask
      logic [IDX_W-1:0] low_q;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          low_q <= word_addr_i[IDX_W-1:0];
        end
        idx_q <= low_q;
      end
    end else begin : g_recip
      // Exact quotient by multiplying with a rounded-up reciprocal.
      localparam int unsigned SHIFT = 30 + IDX_W;
      localparam logic [63:0] SCALE =
        ((64'd1 << SHIFT) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);
      localparam logic [31:0] RECIP = SCALE[31:0];
      localparam logic [29:0] DEPTH = 30'(MEM_WORDS);

      logic [61:0]      prod_d;
      logic [61:0]      prod_q;
      logic [29:0]      addr_q;
      logic [61-SHIFT:0] quot;
      logic [29:0]      qm;
      logic [29:0]      rem;
      logic [29:0]      rem_fix;

      assign prod_d  = {32'd0, word_addr_i} * {30'd0, RECIP};
      assign quot    = prod_q[61:SHIFT];
      assign qm      = 30'(quot) * DEPTH;
      assign rem     = addr_q - qm;
      assign rem_fix = (rem >= DEPTH) ? rem - DEPTH : rem;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          prod_q <= prod_d;
          addr_q <= word_addr_i;
        end
        idx_q <= rem_fix[IDX_W-1:0];
      end
    end
  endgenerate

  assign idx_o = idx_q;

endmodule

`default_nettype wire

// File: design/rvss_regfile.sv
`default_nettype none

module rvss_regfile (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [rvss_pkg::RF_AW-1:0] raddr_a_i,
  input  wire logic [rvss_pkg::RF_AW-1:0] raddr_b_i,
  output logic      [31:0]                rdata_a_o,
  output logic      [31:0]                rdata_b_o,
  input  wire logic                       we_i,
  input  wire logic [rvss_pkg::RF_AW-1:0] waddr_i,
  input  wire logic [31:0]                wdata_i
);

  logic [31:0]                    regs_q [rvss_pkg::REG_COUNT];
  logic [rvss_pkg::REG_COUNT-1:0] valid_q;
  logic [31:0]                    rd_a_q;
  logic [31:0]                    rd_b_q;
  logic                           vld_a_q;
  logic                           vld_b_q;
  logic                           wr_en;

  // x0 is never written, so its valid bit stays clear and it reads zero.
  assign wr_en = we_i && (waddr_i != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[waddr_i] <= 1'b1;
      end
      vld_a_q <= valid_q[raddr_a_i];
      vld_b_q <= valid_q[raddr_b_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      regs_q[waddr_i] <= wdata_i;
    end
    rd_a_q <= regs_q[raddr_a_i];
    rd_b_q <= regs_q[raddr_b_i];
  end

  assign rdata_a_o = vld_a_q ? rd_a_q : 32'd0;
  assign rdata_b_o = vld_b_q ? rd_b_q : 32'd0;

endmodule

`default_nettype wire

// File: design/rvss_useq.sv
`default_nettype none

module rvss_useq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rvss_pkg::stat_t stat_i,
  output rvss_pkg::ctrl_t      cw_o,
  output logic                 idle_o
);

  logic [rvss_pkg::UPC_W-1:0] upc_q;
  logic [rvss_pkg::UPC_W-1:0] upc_d;
  rvss_pkg::ctrl_t            cw;

  assign cw = rvss_pkg::ucode_rom(upc_q);

  always_comb begin
    case (cw.jump)
      rvss_pkg::J_NEXT:   upc_d = upc_q + 1'b1;
      rvss_pkg::J_ALWAYS: upc_d = cw.target;
      rvss_pkg::J_DISPATCH: begin
        if (!stat_i.in_accept) begin
          upc_d = upc_q;
        end else if (stat_i.in_exec) begin
          upc_d = cw.target;
        end else begin
          upc_d = upc_q + 1'b1;
        end
      end
      rvss_pkg::J_NOMEM:  upc_d = stat_i.is_mem ? upc_q + 1'b1 : cw.target;
      rvss_pkg::J_WBWAIT: upc_d = stat_i.out_busy ? upc_q : cw.target;
      default:            upc_d = rvss_pkg::UPC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= rvss_pkg::UPC_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign cw_o   = cw;
  assign idle_o = (upc_q == rvss_pkg::UPC_IDLE);

endmodule

`default_nettype wire

// File: design/rvss_datapath.sv
`default_nettype none

module rvss_datapath #(
  parameter int unsigned MEM_WORDS = 1024,
  parameter int unsigned IDX_W     = 10
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rvss_pkg::ctrl_t cw_i,
  input  wire logic            in_accept_i,
  input  wire logic [9:0]      load_index_i,
  input  wire logic [31:0]     load_word_i,
  input  wire logic            cfg_we_i,
  input  wire logic [31:0]     start_pc_i,
  input  wire logic            out_stall_i,
  output logic                 is_mem_o,
  output logic                 out_busy_o,
  output logic                 out_valid_o,
  output logic      [31:0]     step_pc_o,
  output logic      [31:0]     instruction_o,
  output logic                 wrote_o,
  output logic      [3:0]      dest_reg_o,
  output logic      [31:0]     dest_value_o
);

  logic [31:0]      imem_q [MEM_WORDS];
  logic [31:0]      dmem_q [MEM_WORDS];
  logic [31:0]      imem_rd_q;
  logic [31:0]      dmem_rd_q;

  logic [31:0]      pc_q;
  logic [31:0]      insn_q;
  logic [9:0]       load_index_q;
  logic [31:0]      load_word_q;
  logic [31:0]      value_q;
  logic [31:0]      value_d;
  logic [31:0]      next_pc_q;
  logic [1:0]       addr_lo_q;
  logic             wr_q;

  logic [6:0]       opc;
  logic [3:0]       rd;
  logic [2:0]       f3;
  logic [31:0]      imm_i;
  logic [31:0]      imm_s;
  logic [31:0]      rs1_val;
  logic [31:0]      rs2_val;
  logic [31:0]      addr_sum;
  logic [31:0]      pc_plus4;
  logic             wr_kind;
  logic             is_load;
  logic             is_store;

  logic             red_en;
  logic [29:0]      red_in;
  logic [IDX_W-1:0] idx;
  logic [7:0]       load_byte;
  logic [31:0]      sb_word;
  logic             dmem_we;
  logic [31:0]      dmem_wdata;
  logic             wb_fire;
  logic             out_valid_q;

  assign opc      = insn_q[6:0];
  assign rd       = insn_q[10:7];
  assign f3       = insn_q[14:12];
  assign imm_i    = {{20{insn_q[31]}}, insn_q[31:20]};
  assign imm_s    = {{20{insn_q[31]}}, insn_q[31:25], insn_q[11:7]};
  assign is_load  = (opc == rvss_pkg::OPC_LOAD);
  assign is_store = (opc == rvss_pkg::OPC_STORE);
  assign wr_kind  = (opc == rvss_pkg::OPC_LUI) || (opc == rvss_pkg::OPC_JALR) ||
                    (opc == rvss_pkg::OPC_ADDI) || (opc == rvss_pkg::OPC_ADD) || is_load;
  assign addr_sum = rs1_val + (is_store ? imm_s : imm_i);
  assign pc_plus4 = pc_q + 32'd4;

  rvss_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .raddr_a_i (insn_q[18:15]),
    .raddr_b_i (insn_q[23:20]),
    .rdata_a_o (rs1_val),
    .rdata_b_o (rs2_val),
    .we_i      (wb_fire && wr_q),
    .waddr_i   (rd),
    .wdata_i   (value_q)
  );

  always_comb begin
    case (cw_i.red_src)
      rvss_pkg::RED_PC:   red_in = pc_q[31:2];
      rvss_pkg::RED_ADDR: red_in = addr_sum[31:2];
      rvss_pkg::RED_LOAD: red_in = {20'd0, load_index_q};
      default:            red_in = 30'd0;
    endcase
  end

  assign red_en = (cw_i.red_src != rvss_pkg::RED_HOLD);

  rvss_idxmod #(
    .MEM_WORDS (MEM_WORDS),
    .IDX_W     (IDX_W)
  ) u_idxmod (
    .clk_i       (clk_i),
    .en_i        (red_en),
    .word_addr_i (red_in),
    .idx_o       (idx)
  );

  always_comb begin
    case (opc)
      rvss_pkg::OPC_LUI:  value_d = {insn_q[31:12], 12'd0};
      rvss_pkg::OPC_JALR: value_d = pc_plus4;
      rvss_pkg::OPC_ADDI: value_d = addr_sum;
      rvss_pkg::OPC_ADD:  value_d = rs1_val + rs2_val;
      default:            value_d = 32'd0;
    endcase
  end

  always_comb begin
    case (addr_lo_q)
      2'd0: begin
        load_byte = dmem_rd_q[7:0];
        sb_word   = {dmem_rd_q[31:8], rs2_val[7:0]};
      end
      2'd1: begin
        load_byte = dmem_rd_q[15:8];
        sb_word   = {dmem_rd_q[31:16], rs2_val[7:0], dmem_rd_q[7:0]};
      end
      2'd2: begin
        load_byte = dmem_rd_q[23:16];
        sb_word   = {dmem_rd_q[31:24], rs2_val[7:0], dmem_rd_q[15:0]};
      end
      default: begin
        load_byte = dmem_rd_q[31:24];
        sb_word   = {rs2_val[7:0], dmem_rd_q[23:0]};
      end
    endcase
  end

  // The data store has one write port, shared by program loads and stores.
  assign dmem_we    = cw_i.load_wr || (cw_i.mem_op && is_store);
  assign dmem_wdata = cw_i.load_wr ? load_word_q :
                      (f3 == rvss_pkg::F3_BYTE) ? sb_word : rs2_val;

  always_ff @(posedge clk_i) begin
    if (cw_i.load_wr) begin
      imem_q[idx] <= load_word_q;
    end
    imem_rd_q <= imem_q[idx];
  end

  always_ff @(posedge clk_i) begin
    if (dmem_we) begin
      dmem_q[idx] <= dmem_wdata;
    end
    dmem_rd_q <= dmem_q[idx];
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      load_index_q <= load_index_i;
      load_word_q  <= load_word_i;
    end
    if (cw_i.insn_ld) begin
      insn_q <= imem_rd_q;
    end
    if (cw_i.alu_ld) begin
      value_q   <= value_d;
      next_pc_q <= (opc == rvss_pkg::OPC_JALR) ? {addr_sum[31:1], 1'b0} : pc_plus4;
      addr_lo_q <= addr_sum[1:0];
      wr_q      <= wr_kind;
    end else if (cw_i.mem_op && is_load) begin
      value_q <= (f3 == rvss_pkg::F3_WORD) ? dmem_rd_q : {24'd0, load_byte};
    end
  end

  assign out_busy_o = out_valid_q && out_stall_i;
  assign wb_fire    = cw_i.wb && !out_busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pc_q <= start_pc_i;
      end else if (wb_fire) begin
        pc_q <= next_pc_q;
      end
      if (wb_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_fire) begin
      step_pc_o     <= pc_q;
      instruction_o <= insn_q;
      wrote_o       <= wr_q;
      dest_reg_o    <= wr_q ? rd : 4'd0;
      dest_value_o  <= (wr_q && rd != 4'd0) ? value_q : 32'd0;
    end
  end

  assign is_mem_o    = is_load || is_store;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: tb/sv/tb_rv32e_subset_core_step.sv
module tb_rv32e_subset_core_step;
  import rvss_pkg::*;

  localparam int unsigned MEM_WORDS    = 1024;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned CHUNKS       = 3;
  localparam int unsigned CHUNK_ITEMS  = 12;

  // Funct3 values for operations that ignore funct3, and a non-canonical width.
  localparam logic [2:0] F3_NONE = 3'b000;
  localparam logic [2:0] F3_ALT  = 3'b111;

  typedef struct packed {
    logic        opcode;
    logic [9:0]  index;
    logic [31:0] word;
  } core_item_t;

  typedef struct packed {
    logic [31:0] step_pc;
    logic [31:0] instruction;
    logic        wrote;
    logic [3:0]  dest_reg;
    logic [31:0] dest_value;
  } step_result_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic        opcode_i     = ITEM_LOAD;
  logic [9:0]  load_index_i = '0;
  logic [31:0] load_word_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [31:0] step_pc_o;
  logic [31:0] instruction_o;
  logic        wrote_o;
  logic [3:0]  dest_reg_o;
  logic [31:0] dest_value_o;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] start_pc_i   = '0;

  core_item_t   pending_items[$];
  step_result_t expected_steps[$];

  // Shadow copy of the core's architectural state.
  logic [31:0] prog_counter = '0;
  logic [31:0] reg_file [REG_COUNT];
  logic [31:0] imem_copy [MEM_WORDS];
  logic [31:0] dmem_copy [MEM_WORDS];

  int unsigned sender_idle_pct   = 37;
  int unsigned receiver_idle_pct = 61;
  int unsigned mismatch_count    = 0;
  int unsigned cycle_count       = 0;

  rv32e_subset_core_step #(
    .MEM_WORDS(MEM_WORDS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .load_index_i (load_index_i),
    .load_word_i  (load_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .step_pc_o    (step_pc_o),
    .instruction_o(instruction_o),
    .wrote_o      (wrote_o),
    .dest_reg_o   (dest_reg_o),
    .dest_value_o (dest_value_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .start_pc_i   (start_pc_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  function automatic int unsigned word_slot(input logic [31:0] addr);
    return (addr >> 2) % MEM_WORDS;
  endfunction

  function automatic logic [31:0] enc_itype(input logic [6:0] opc, input logic [4:0] rd,
                                            input logic [2:0] f3, input logic [4:0] rs1,
                                            input logic [11:0] imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_stype(input logic [2:0] f3, input logic [4:0] rs1,
                                            input logic [4:0] rs2, input logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  // Mostly well-formed instructions with random fields. Half of the memory
  // accesses use a zero base and a small offset so that stores and loads
  // keep hitting the same few words.
  function automatic logic [31:0] random_program_word();
    logic [31:0] w;
    logic [11:0] near;
    logic [1:0]  bits;
    int unsigned pick;
    w    = $urandom;
    near = 12'($urandom_range(63));
    bits = 2'($urandom);
    pick = $urandom_range(99);
    if (pick < 12) begin
      w[6:0] = OPC_LUI;
    end else if (pick < 17) begin
      w[6:0] = OPC_JALR;
    end else if (pick < 37) begin
      w[6:0] = OPC_ADDI;
    end else if (pick < 52) begin
      w[6:0] = OPC_ADD;
    end else if (pick < 70) begin
      w[6:0] = OPC_LOAD;
      if (pick < 61) w[14:12] = F3_WORD;
      if (bits[0]) begin
        w[19:15] = {bits[1], 4'b0000};
        w[31:20] = near;
      end
    end else if (pick < 88) begin
      w[6:0] = OPC_STORE;
      if (pick < 79) w[14:12] = F3_BYTE;
      if (bits[0]) begin
        w[19:15] = {bits[1], 4'b0000};
        {w[31:25], w[11:7]} = near;
      end
    end
    return w;
  endfunction

  // Executes the instruction at the current pc on the shadow state.
  function automatic step_result_t execute_step();
    step_result_t res;
    logic [31:0] insn, a, b, imm_i, imm_s, addr, value, next_pc;
    logic [6:0]  opc;
    logic [3:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [4:0]  shift;
    logic        wr;
    int unsigned slot;
    insn    = imem_copy[word_slot(prog_counter)];
    opc     = insn[6:0];
    rd      = insn[10:7];
    f3      = insn[14:12];
    rs1     = insn[18:15];
    rs2     = insn[23:20];
    imm_i   = {{20{insn[31]}}, insn[31:20]};
    imm_s   = {{20{insn[31]}}, insn[31:25], insn[11:7]};
    a       = reg_file[rs1];
    b       = reg_file[rs2];
    next_pc = prog_counter + 32'd4;
    value   = '0;
    wr      = 1'b0;
    case (opc)
      OPC_LUI: begin
        value = {insn[31:12], 12'h000};
        wr    = 1'b1;
      end
      OPC_JALR: begin
        value   = prog_counter + 32'd4;
        next_pc = (a + imm_i) & ~32'd1;
        wr      = 1'b1;
      end
      OPC_ADDI: begin
        value = a + imm_i;
        wr    = 1'b1;
      end
      OPC_ADD: begin
        value = a + b;
        wr    = 1'b1;
      end
      OPC_LOAD: begin
        addr  = a + imm_i;
        shift = {addr[1:0], 3'b000};
        if (f3 == F3_WORD) value = dmem_copy[word_slot(addr)];
        else value = (dmem_copy[word_slot(addr)] >> shift) & 32'h0000_00FF;
        wr = 1'b1;
      end
      OPC_STORE: begin
        addr  = a + imm_s;
        slot  = word_slot(addr);
        shift = {addr[1:0], 3'b000};
        if (f3 == F3_BYTE) begin
          dmem_copy[slot] = (dmem_copy[slot] & ~(32'h0000_00FF << shift)) |
                            ({24'h0, b[7:0]} << shift);
        end else begin
          dmem_copy[slot] = b;
        end
      end
      default: ;
    endcase
    if (wr && rd != 4'd0) reg_file[rd] = value;
    res.step_pc     = prog_counter;
    res.instruction = insn;
    res.wrote       = wr;
    res.dest_reg    = wr ? rd : 4'd0;
    res.dest_value  = wr ? reg_file[rd] : 32'd0;
    prog_counter    = next_pc;
    return res;
  endfunction

  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR cycle %0d: %s", cycle_count, msg);
  endfunction

  function automatic void queue_item(input logic op, input logic [9:0] index,
                                     input logic [31:0] word);
    core_item_t item;
    item.opcode = op;
    item.index  = index;
    item.word   = word;
    pending_items = {pending_items, item};
  endfunction

  // Input side: the beat at the head of the queue is held while stalled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (pending_items[0].opcode == ITEM_LOAD) begin
          imem_copy[pending_items[0].index % MEM_WORDS] = pending_items[0].word;
          dmem_copy[pending_items[0].index % MEM_WORDS] = pending_items[0].word;
        end else begin
          expected_steps = {expected_steps, execute_step()};
        end
        void'(pending_items.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid_i   <= 1'b1;
          opcode_i     <= pending_items[0].opcode;
          load_index_i <= pending_items[0].index;
          load_word_i  <= pending_items[0].word;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output side: compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    step_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_steps.size() == 0) begin
        note_failure($sformatf("unexpected result pc %h insn %h", step_pc_o, instruction_o));
      end else begin
        want = expected_steps.pop_front();
        if (step_pc_o !== want.step_pc)
          note_failure($sformatf("step_pc expected %h got %h", want.step_pc, step_pc_o));
        if (instruction_o !== want.instruction)
          note_failure($sformatf("instruction expected %h got %h",
                                 want.instruction, instruction_o));
        if (wrote_o !== want.wrote)
          note_failure($sformatf("wrote expected %b got %b (pc %h insn %h)",
                                 want.wrote, wrote_o, want.step_pc, want.instruction));
        if (dest_reg_o !== want.dest_reg)
          note_failure($sformatf("dest_reg expected %0d got %0d (pc %h insn %h)",
                                 want.dest_reg, dest_reg_o, want.step_pc, want.instruction));
        if (dest_value_o !== want.dest_value)
          note_failure($sformatf("dest_value expected %h got %h (pc %h insn %h)",
                                 want.dest_value, dest_value_o, want.step_pc,
                                 want.instruction));
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < receiver_idle_pct);
  end

  // Waits until every queued beat is accepted and every result has come back,
  // then lets a trailing load finish inside the core.
  task automatic drain();
    while (pending_items.size() != 0 || expected_steps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_start_pc(input logic [31:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    start_pc_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    prog_counter = value;
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("rv32e_subset_core_step test failed");
    $finish;
  end

  initial begin
    logic [31:0] boot_words [14];
    logic [31:0] phase_pc [PHASES];
    for (int r = 0; r < REG_COUNT; r++) reg_file[r] = '0;
    // A short program that walks through every instruction kind, the register
    // index folding, x0 as destination, byte lanes and address wrap-around.
    boot_words = '{
      {20'hFFFFF, 5'd1, OPC_LUI},
      enc_itype(OPC_ADDI, 5'd2, F3_NONE, 5'd0, 12'hFFF),
      {7'd0, 5'd2, 5'd1, F3_NONE, 5'd3, OPC_ADD},
      enc_itype(OPC_ADDI, 5'd0, F3_NONE, 5'd1, 12'h7FF),
      enc_itype(OPC_ADDI, 5'd31, F3_NONE, 5'd17, 12'h800),
      enc_stype(F3_BYTE, 5'd0, 5'd2, 12'h001),
      enc_itype(OPC_LOAD, 5'd4, F3_WORD, 5'd0, 12'h000),
      enc_itype(OPC_LOAD, 5'd5, F3_BYTE, 5'd0, 12'h001),
      enc_stype(F3_ALT, 5'd0, 5'd1, 12'h008),
      enc_itype(OPC_LOAD, 5'd6, F3_ALT, 5'd0, 12'h00B),
      enc_itype(OPC_LOAD, 5'd7, F3_WORD, 5'd0, 12'hFFC),
      32'h0000_0000,
      enc_itype(OPC_JALR, 5'd8, F3_NONE, 5'd2, 12'h035),
      32'hFFFF_FFFF
    };
    phase_pc = '{32'hFFFF_FFFF, $urandom, 32'h0000_0000, $urandom, 32'hFFFF_FFFC, $urandom};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill both stores completely so that no fetch or data access can ever
    // touch a word that was never written.
    @(negedge clk_i);
    for (int i = 0; i < MEM_WORDS; i++) begin
      queue_item(ITEM_LOAD, 10'(i), (i < 14) ? boot_words[i] : random_program_word());
    end
    drain();
    write_start_pc(32'h0000_0000);
    @(negedge clk_i);
    repeat (15) queue_item(ITEM_EXEC, 10'($urandom), $urandom);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 2) begin
        sender_idle_pct   = 61;
        receiver_idle_pct = 37;
      end else if (p == 4) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      write_start_pc(phase_pc[p]);
      for (int c = 0; c < CHUNKS; c++) begin
        @(negedge clk_i);
        for (int k = 0; k < CHUNK_ITEMS; k++) begin
          if ($urandom_range(99) < 25)
            queue_item(ITEM_LOAD, 10'($urandom), random_program_word());
          else
            queue_item(ITEM_EXEC, 10'($urandom), $urandom);
        end
        drain();
      end
    end

    if (mismatch_count == 0) begin
      $display("rv32e_subset_core_step test passed");
    end else begin
      $display("rv32e_subset_core_step test failed");
    end
    $finish;
  end

endmodule
